// ===== sv/float_add_sub_unpacked_macros.svh =====
// Assertion macros for the floating-point add/subtract unit.
`ifndef FLOAT_ADD_SUB_UNPACKED_MACROS_SVH
`define FLOAT_ADD_SUB_UNPACKED_MACROS_SVH
`ifndef ASSERT_OFF
`define FAS_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define FAS_ASSERT_NOW(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`else
`define FAS_ASSERT_IMPL(label, clk, rst_n, prop)
`define FAS_ASSERT_NOW(label, clk, rst_n, cond)
`endif
`endif

// ===== sv/fas_pkg.sv =====
// Shared types and constants for the floating-point add/subtract unit.
`default_nettype none
package fas_pkg;
    localparam int MANT_BITS = 24;
    localparam int EXP_BITS  = 8;
    localparam int GRS       = 3;
    localparam int SUM_BITS  = MANT_BITS + GRS + 1;
    localparam int EXT_BITS  = EXP_BITS + 2;
    localparam int LZ_BITS   = $clog2(SUM_BITS + 1);
    localparam int IN_BITS   = 2 * (1 + EXP_BITS + MANT_BITS) + 1;
    localparam int OUT_BITS  = 1 + EXP_BITS + MANT_BITS + 2;
    localparam logic [1:0] FLAG_NORMAL    = 2'd0;
    localparam logic [1:0] FLAG_OVERFLOW  = 2'd1;
    localparam logic [1:0] FLAG_UNDERFLOW = 2'd2;

    // Operand after input normalization; exponent is signed and widened.
    typedef struct packed {
        logic                        zero;
        logic                        sign;
        logic signed [EXT_BITS-1:0]  expo;
        logic [MANT_BITS-1:0]        mant;
    } operand_t;

    // Leading-zero count of a vector of SUM_BITS bits.
    function automatic logic [LZ_BITS-1:0] lzc(input logic [SUM_BITS-1:0] v);
        logic [LZ_BITS-1:0] n;
        logic               found;
        n = LZ_BITS'(SUM_BITS);
        found = 1'b0;
        for (int i = SUM_BITS - 1; i >= 0; i--) begin
            if (v[i] && !found) begin
                n = LZ_BITS'(SUM_BITS - 1 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction
endpackage
`default_nettype wire

// ===== sv/fas_norm_in.sv =====
// Input operand normalization: zero detect and leading-one shift.
`default_nettype none
module fas_norm_in
    import fas_pkg::*;
(
    input  wire logic                 sign,
    input  wire logic [EXP_BITS-1:0]  expo,
    input  wire logic [MANT_BITS-1:0] mant,
    output operand_t                  op
);
    logic [SUM_BITS-1:0] ext;
    logic [LZ_BITS-1:0]  lz;

    // Count leading zeros inside the significand field only.
    always_comb
    begin
        ext = {mant, {(SUM_BITS - MANT_BITS){1'b0}}};
        lz = lzc(ext);
        op.zero = (expo == '0) || (mant == '0);
        op.sign = sign;
        op.mant = MANT_BITS'(mant << lz);
        op.expo = $signed({2'b00, expo}) - $signed({{(EXT_BITS - LZ_BITS){1'b0}}, lz});
    end
endmodule
`default_nettype wire

// ===== sv/float_add_sub_unpacked.sv =====
// Top level of the pipelined floating-point add/subtract unit.
//  channel | dir | handshake          | content
//  s_axis  | in  | tvalid/tready      | tdata: operands and request type
//  m_axis  | out | tvalid/tready      | tdata: result and range flag
// Four register stages: normalize/swap, align, add, normalize/round.
// One word enters every clock while the output is not stalled.
// Reset clears only the stage valid bits.
// A stall at the output holds each full stage with only full stages after it; other stages still move.
`default_nettype none
`include "float_add_sub_unpacked_macros.svh"
module float_add_sub_unpacked
    import fas_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // req_type, a_sign, a_exp, a_mant, b_sign, b_exp, b_mant, zero fill
    input  wire logic [((IN_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // r_sign, r_exp, r_mant, range_flag, zero fill
    output logic [((OUT_BITS+7)/8)*8-1:0] m_axis_tdata
);
    localparam int PA = 1;
    localparam int PB = PA + 1 + EXP_BITS + MANT_BITS;

    operand_t opa, opb;
    logic [3:0] v_reg;
    logic [3:0] adv;

    // Stall chain: a stage moves when it is empty or the next moves.
    always_comb
    begin
        adv[3] = !v_reg[3] || m_axis_tready;
        adv[2] = !v_reg[2] || adv[3];
        adv[1] = !v_reg[1] || adv[2];
        adv[0] = !v_reg[0] || adv[1];
    end
    assign s_axis_tready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[0]) v_reg[0] <= s_axis_tvalid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
            if (adv[3]) v_reg[3] <= v_reg[2];
        end
    end

    fas_norm_in u_na (
        .sign (s_axis_tdata[PA]),
        .expo (s_axis_tdata[PA+1 +: EXP_BITS]),
        .mant (s_axis_tdata[PA+1+EXP_BITS +: MANT_BITS]),
        .op   (opa)
    );
    fas_norm_in u_nb (
        .sign (s_axis_tdata[PB] ^ s_axis_tdata[0]),
        .expo (s_axis_tdata[PB+1 +: EXP_BITS]),
        .mant (s_axis_tdata[PB+1+EXP_BITS +: MANT_BITS]),
        .op   (opb)
    );

    // Stage 1: order the operands by magnitude.
    operand_t big_reg, sml_reg;
    logic     bothz_reg;
    logic     a_first;
    always_comb
    begin
        a_first = opb.zero || (!opa.zero && (opa.expo > opb.expo ||
                  (opa.expo == opb.expo && opa.mant >= opb.mant)));
    end
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            bothz_reg <= opa.zero && opb.zero;
            big_reg   <= a_first ? opa : opb;
            sml_reg   <= a_first ? opb : opa;
        end
    end

    // Stage 2: align the smaller significand with a sticky bit.
    localparam int XW = MANT_BITS + GRS;
    logic [XW-1:0]         x1_reg, x2_reg;
    logic                  s1_reg, eff_sub_reg, bothz2_reg;
    logic signed [EXT_BITS-1:0] e1_reg;
    logic [EXT_BITS-1:0]   shift_amt;
    logic [XW-1:0]         full, x2n, lost;
    always_comb
    begin
        shift_amt = EXT_BITS'(big_reg.expo - sml_reg.expo);
        full = {sml_reg.mant, {GRS{1'b0}}};
        lost = '0;
        if (sml_reg.zero)
            x2n = '0;
        else if (shift_amt >= EXT_BITS'(XW))
            x2n = XW'(1);
        else
        begin
            lost = full & ((XW'(1) << shift_amt) - XW'(1));
            x2n  = (full >> shift_amt) | XW'(lost != '0);
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            x1_reg      <= {big_reg.mant, {GRS{1'b0}}};
            x2_reg      <= x2n;
            s1_reg      <= big_reg.sign;
            eff_sub_reg <= big_reg.sign != sml_reg.sign;
            e1_reg      <= big_reg.expo;
            bothz2_reg  <= bothz_reg;
        end
    end

    // Stage 3: add or subtract.
    logic [SUM_BITS-1:0]        sum_reg;
    logic                       s3_reg, bothz3_reg;
    logic signed [EXT_BITS-1:0] e3_reg;
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            sum_reg    <= eff_sub_reg ? {1'b0, x1_reg} - {1'b0, x2_reg}
                                      : {1'b0, x1_reg} + {1'b0, x2_reg};
            s3_reg     <= s1_reg;
            e3_reg     <= e1_reg;
            bothz3_reg <= bothz2_reg;
        end
    end

    // Stage 4: normalize, round to nearest even, range check.
    logic [LZ_BITS-1:0]         lz;
    logic [SUM_BITS-1:0]        sh;
    logic [MANT_BITS:0]         q;
    logic signed [EXT_BITS-1:0] e4;
    logic [2:0]                 low;
    logic [OUT_BITS-1:0]        res;
    logic [((OUT_BITS+7)/8)*8-1:0] out_reg;
    always_comb
    begin
        lz = lzc(sum_reg);
        e4 = e3_reg;
        if (sum_reg[SUM_BITS-1])
        begin
            sh = {1'b0, sum_reg[SUM_BITS-1:2], sum_reg[1] | sum_reg[0]};
            e4 = e3_reg + EXT_BITS'(1);
        end
        else
        begin
            sh = sum_reg << (lz - LZ_BITS'(1));
            e4 = e3_reg - $signed({{(EXT_BITS-LZ_BITS){1'b0}}, lz}) + EXT_BITS'(1);
        end
        low = sh[2:0];
        q   = {1'b0, sh[SUM_BITS-2:GRS]};
        if (low > 3'd4 || (low == 3'd4 && q[0]))
            q = q + (MANT_BITS+1)'(1);
        if (q[MANT_BITS])
        begin
            q  = q >> 1;
            e4 = e4 + EXT_BITS'(1);
        end
        if (bothz3_reg || sum_reg == '0)
            res = {FLAG_NORMAL, {MANT_BITS{1'b0}}, {EXP_BITS{1'b0}}, 1'b0};
        else if (e4 > $signed(EXT_BITS'({EXP_BITS{1'b1}})))
            res = {FLAG_OVERFLOW, {MANT_BITS{1'b1}}, {EXP_BITS{1'b1}}, s3_reg};
        else if (e4 < $signed(EXT_BITS'(1)))
            res = {FLAG_UNDERFLOW, {MANT_BITS{1'b0}}, {EXP_BITS{1'b0}}, 1'b0};
        else
            res = {FLAG_NORMAL, q[MANT_BITS-1:0], e4[EXP_BITS-1:0], s3_reg};
    end
    always_ff @(posedge clk)
    begin
        if (adv[3])
            out_reg <= {{(((OUT_BITS+7)/8)*8-OUT_BITS){1'b0}}, res};
    end
    assign m_axis_tvalid = v_reg[3];
    assign m_axis_tdata  = out_reg;

    // A normal result with a nonzero exponent carries its leading one.
    `FAS_ASSERT_NOW(a_lead_one, clk, rst_n, !m_axis_tvalid || m_axis_tdata[OUT_BITS-1 -: 2] != FLAG_NORMAL || m_axis_tdata[1+EXP_BITS+MANT_BITS-1] || m_axis_tdata[1 +: EXP_BITS] == '0)
    // A held output keeps its word.
    `FAS_ASSERT_IMPL(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    // An underflow result is zero; this check covers its exponent and significand.
    `FAS_ASSERT_NOW(a_uflow, clk, rst_n, !m_axis_tvalid || m_axis_tdata[OUT_BITS-1 -: 2] != FLAG_UNDERFLOW || m_axis_tdata[1 +: EXP_BITS+MANT_BITS] == '0)
endmodule
`default_nettype wire
